/* rtl/setx_pkg.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// setx_pkg
// Shared types and constants of the sprite entry tile expander.
// ----------------------------------------------------------------------------
package setx_pkg;

	localparam int unsigned QUEUE_DEPTH = 2;
	localparam int unsigned QUEUE_AW    = $clog2(QUEUE_DEPTH);

	localparam logic [15:0] ATTR_FLIP_X   = 16'h0001;
	localparam logic [15:0] ATTR_FLIP_Y   = 16'h0002;
	localparam logic [15:0] ATTR_ENABLE   = 16'h0004;
	localparam logic [15:0] ATTR_PRIORITY = 16'h0020;
	localparam logic [15:0] ATTR_FLICKER  = 16'h0040;

	typedef struct packed {
		logic [15:0] code;
		logic [3:0]  color;
		logic        flip_x;
		logic        flip_y;
		logic [1:0]  size_code;
		logic [15:0] sx;
		logic [15:0] sy;
	} sprite_entry_t;

	typedef struct packed {
		logic push;
		logic pop;
	} queue_ctrl_t;

	typedef struct packed {
		logic full;
		logic empty;
	} queue_stat_t;

	function automatic logic [5:0] morton3(input logic [2:0] col, input logic [2:0] row);
		morton3 = {row[2], col[2], row[1], col[1], row[0], col[0]};
	endfunction

endpackage

/* rtl/setx_front.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// setx_front
// Holds the scroll register, accepts sprite entries, drops entries that are
// not drawn and pushes drawn ones with their scrolled x into the queue.
// ----------------------------------------------------------------------------
module setx_front
	import setx_pkg::*;
(
	input  logic                clk,
	input  logic                arst_n,
	input  logic                cfg_valid,
	input  logic [8:0]          cfg_data,
	input  logic                in_valid,
	output logic                in_ready,
	input  logic [15:0]         attr_word,
	input  logic [15:0]         code_word,
	input  logic [15:0]         color_word,
	input  logic [15:0]         y_word,
	input  logic [15:0]         x_word,
	input  logic                frame_odd,
	input  logic                priority_pass,
	input  queue_stat_t         q_stat,
	output logic                q_push,
	output sprite_entry_t       q_entry
);

	logic [8:0] x_offset_q;
	logic       drawn;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			x_offset_q <= '0;
		end else if (cfg_valid) begin
			x_offset_q <= cfg_data;
		end
	end

	always_comb begin
		drawn = ((attr_word & ATTR_ENABLE) != '0)
			&& (((attr_word & ATTR_FLICKER) == '0) || frame_odd)
			&& (((attr_word & ATTR_PRIORITY) != '0) == priority_pass);
		in_ready          = !q_stat.full;
		q_push            = in_valid && in_ready && drawn;
		q_entry.code      = code_word;
		q_entry.color     = color_word[7:4];
		q_entry.flip_x    = (attr_word & ATTR_FLIP_X) != '0;
		q_entry.flip_y    = (attr_word & ATTR_FLIP_Y) != '0;
		q_entry.size_code = color_word[1:0];
		q_entry.sx        = x_word + {{7{x_offset_q[8]}}, x_offset_q};
		q_entry.sy        = y_word;
	end

endmodule

/* rtl/setx_queue.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// setx_queue
// Short entry queue between the front and the tile sequencer.
// ----------------------------------------------------------------------------
module setx_queue
	import setx_pkg::*;
(
	input  logic          clk,
	input  logic          arst_n,
	input  queue_ctrl_t   ctrl,
	input  sprite_entry_t wr_entry,
	output sprite_entry_t rd_entry,
	output queue_stat_t   stat
);

	sprite_entry_t             mem_q [QUEUE_DEPTH];
	logic [QUEUE_AW-1:0]       wr_ptr_q;
	logic [QUEUE_AW-1:0]       rd_ptr_q;
	logic [QUEUE_AW:0]         count_q;

	always_comb begin
		stat.full  = count_q == (QUEUE_AW+1)'(QUEUE_DEPTH);
		stat.empty = count_q == '0;
		rd_entry   = mem_q[rd_ptr_q];
	end

	always_ff @(posedge clk) begin
		if (ctrl.push) begin
			mem_q[wr_ptr_q] <= wr_entry;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (ctrl.push) begin
				wr_ptr_q <= (wr_ptr_q == QUEUE_AW'(QUEUE_DEPTH - 1)) ? '0 : wr_ptr_q + 1'b1;
			end
			if (ctrl.pop) begin
				rd_ptr_q <= (rd_ptr_q == QUEUE_AW'(QUEUE_DEPTH - 1)) ? '0 : rd_ptr_q + 1'b1;
			end
			case ({ctrl.push, ctrl.pop})
				2'b10:   count_q <= count_q + 1'b1;
				2'b01:   count_q <= count_q - 1'b1;
				default: count_q <= count_q;
			endcase
		end
	end

endmodule

/* rtl/setx_back.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// setx_back
// Tile sequencer: walks the rows and columns of one sprite and loads one
// tile command a cycle into the output register while out_ready does not stall it.
// ----------------------------------------------------------------------------
module setx_back
	import setx_pkg::*;
(
	input  logic               clk,
	input  logic               arst_n,
	input  queue_stat_t        q_stat,
	input  sprite_entry_t      q_entry,
	output logic               q_pop,
	output logic               out_valid,
	input  logic               out_ready,
	output logic [15:0]        tile_code,
	output logic [3:0]         tile_color,
	output logic               tile_flip_x,
	output logic               tile_flip_y,
	output logic signed [15:0] tile_x,
	output logic signed [15:0] tile_y,
	output logic               last_tile
);

	sprite_entry_t ent_q;
	logic          busy_q;
	logic [2:0]    row_q;
	logic [2:0]    col_q;
	logic          out_valid_q;
	logic [2:0]    mask;
	logic [2:0]    cx;
	logic [2:0]    cy;
	logic          advance;
	logic          is_last;

	always_comb begin
		mask    = 3'((4'd1 << ent_q.size_code) - 4'd1);
		cx      = ent_q.flip_x ? (col_q ^ mask) : col_q;
		cy      = ent_q.flip_y ? (row_q ^ mask) : row_q;
		is_last = (row_q == mask) && (col_q == mask);
		advance = busy_q && (!out_valid_q || out_ready);
		q_pop   = !busy_q && !q_stat.empty;
		out_valid = out_valid_q;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q      <= 1'b0;
			row_q       <= '0;
			col_q       <= '0;
			out_valid_q <= 1'b0;
		end else begin
			if (q_pop) begin
				busy_q <= 1'b1;
				row_q  <= '0;
				col_q  <= '0;
			end else if (advance) begin
				if (is_last) begin
					busy_q <= 1'b0;
				end else if (col_q == mask) begin
					col_q <= '0;
					row_q <= row_q + 1'b1;
				end else begin
					col_q <= col_q + 1'b1;
				end
			end
			if (advance) begin
				out_valid_q <= 1'b1;
			end else if (out_ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (q_pop) begin
			ent_q <= q_entry;
		end
		if (advance) begin
			tile_code   <= ent_q.code + {10'd0, morton3(col_q, row_q)};
			tile_color  <= ent_q.color;
			tile_flip_x <= ent_q.flip_x;
			tile_flip_y <= ent_q.flip_y;
			tile_x      <= ent_q.sx + {10'd0, cx, 3'd0};
			tile_y      <= ent_q.sy + {10'd0, cy, 3'd0};
			last_tile   <= is_last;
		end
	end

endmodule

/* rtl/sprite_entry_tile_expander_unit.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// sprite_entry_tile_expander_unit
// Turns one sprite entry into size by size 8x8 tile commands.
// ----------------------------------------------------------------------------
// path: an entry passes the queue and the sequencer's entry register to the
// output register; a drawn sprite of s tiles a side gives s*s commands, one
// a cycle while out_ready does not stall; an entry not drawn is dropped
// a two-entry queue lets the front take entries while the sequencer works
// reset: asynchronous, clears scroll offset to zero, queue and output valid
module sprite_entry_tile_expander_unit
	import setx_pkg::*;
(
	input  logic               clk,
	input  logic               arst_n,
	input  logic               cfg_valid,
	output logic               cfg_ready,
	input  logic [8:0]         cfg_data,
	input  logic               in_valid,
	output logic               in_ready,
	input  logic [15:0]        attr_word,
	input  logic [15:0]        code_word,
	input  logic [15:0]        color_word,
	input  logic [15:0]        y_word,
	input  logic [15:0]        x_word,
	input  logic               frame_odd,
	input  logic               priority_pass,
	output logic               out_valid,
	input  logic               out_ready,
	output logic [15:0]        tile_code,
	output logic [3:0]         tile_color,
	output logic               tile_flip_x,
	output logic               tile_flip_y,
	output logic signed [15:0] tile_x,
	output logic signed [15:0] tile_y,
	output logic               last_tile
);

	queue_ctrl_t   q_ctrl;
	queue_stat_t   q_stat;
	sprite_entry_t wr_entry;
	sprite_entry_t rd_entry;
	logic          q_push;
	logic          q_pop;

	assign cfg_ready = 1'b1;
	assign q_ctrl.push = q_push;
	assign q_ctrl.pop  = q_pop;

	setx_front u_front (
		.clk           (clk),
		.arst_n        (arst_n),
		.cfg_valid     (cfg_valid),
		.cfg_data      (cfg_data),
		.in_valid      (in_valid),
		.in_ready      (in_ready),
		.attr_word     (attr_word),
		.code_word     (code_word),
		.color_word    (color_word),
		.y_word        (y_word),
		.x_word        (x_word),
		.frame_odd     (frame_odd),
		.priority_pass (priority_pass),
		.q_stat        (q_stat),
		.q_push        (q_push),
		.q_entry       (wr_entry)
	);

	setx_queue u_queue (
		.clk      (clk),
		.arst_n   (arst_n),
		.ctrl     (q_ctrl),
		.wr_entry (wr_entry),
		.rd_entry (rd_entry),
		.stat     (q_stat)
	);

	setx_back u_back (
		.clk         (clk),
		.arst_n      (arst_n),
		.q_stat      (q_stat),
		.q_entry     (rd_entry),
		.q_pop       (q_pop),
		.out_valid   (out_valid),
		.out_ready   (out_ready),
		.tile_code   (tile_code),
		.tile_color  (tile_color),
		.tile_flip_x (tile_flip_x),
		.tile_flip_y (tile_flip_y),
		.tile_x      (tile_x),
		.tile_y      (tile_y),
		.last_tile   (last_tile)
	);

endmodule

/* rtl/setx_checker.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// setx_checker
// Port-level checks of the tile expander, bound to the top level.
// ----------------------------------------------------------------------------
module setx_checker (
	input logic               clk,
	input logic               arst_n,
	input logic               out_valid,
	input logic               out_ready,
	input logic [15:0]        tile_code,
	input logic [3:0]         tile_color,
	input logic               tile_flip_x,
	input logic               tile_flip_y,
	input logic signed [15:0] tile_y,
	input logic               last_tile
);

	// stalled command stays valid and holds its code, y and last flag
	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_ready |=> out_valid && $stable(tile_code) && $stable(tile_y)
			&& $stable(last_tile))
		else $error("stalled tile command changed");

	// tiles of one sprite follow without a gap
	a_no_gap: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && out_ready && !last_tile |=> out_valid)
		else $error("gap inside a sprite");

	// color and flips are the same for all tiles of a sprite
	a_same_sprite: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && out_ready && !last_tile |=> tile_color == $past(tile_color)
			&& tile_flip_x == $past(tile_flip_x) && tile_flip_y == $past(tile_flip_y))
		else $error("sprite attributes changed between tiles");

endmodule

bind sprite_entry_tile_expander_unit setx_checker u_setx_checker (.*);
